// ===== hw/rtl/packet_protocol_classifier_defines.svh =====
// Assertion macros used by the packet protocol classifier counter bank.
`ifndef PACKET_PROTOCOL_CLASSIFIER_DEFINES_SVH
`define PACKET_PROTOCOL_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PPC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ppc_pkg.sv =====
// Shared types and constants for the packet protocol classifier.
`timescale 1ns / 1ps

package ppc_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int NUM_CATS    = 21;
   localparam int INDEX_WIDTH = 5;
   localparam int VALUE_WIDTH = 32;

   // Operation codes
   localparam logic OP_CLASSIFY = 1'b0;
   localparam logic OP_READ     = 1'b1;

   // Ethertypes and protocol numbers
   localparam logic [15:0] ET_VLAN  = 16'h8100;
   localparam logic [15:0] ET_ARP   = 16'h0806;
   localparam logic [15:0] ET_IPV4  = 16'h0800;
   localparam logic [15:0] ET_IPV6  = 16'h86DD;
   localparam logic [7:0]  PR_ICMP4 = 8'd1;
   localparam logic [7:0]  PR_TCP   = 8'd6;
   localparam logic [7:0]  PR_UDP   = 8'd17;
   localparam logic [7:0]  PR_ICMP6 = 8'd58;

   // Well-known ports
   localparam logic [15:0] PORT_DNS      = 16'd53;
   localparam logic [15:0] PORT_SMTP     = 16'd25;
   localparam logic [15:0] PORT_HTTP     = 16'd80;
   localparam logic [15:0] PORT_HTTP_ALT = 16'd8080;
   localparam logic [15:0] PORT_POP3     = 16'd110;
   localparam logic [15:0] PORT_IMAP     = 16'd143;
   localparam logic [15:0] PORT_NETBIOS  = 16'd139;
   localparam logic [15:0] PORT_SMB      = 16'd445;
   localparam logic [15:0] PORT_FTP_DATA = 16'd20;
   localparam logic [15:0] PORT_FTP_CTRL = 16'd21;

   // Category bit positions
   localparam int CAT_VLAN   = 0;
   localparam int CAT_QINQ   = 1;
   localparam int CAT_ARP    = 2;
   localparam int CAT_IPV4   = 3;
   localparam int CAT_UDP    = 4;
   localparam int CAT_TCP    = 5;
   localparam int CAT_ICMP4  = 6;
   localparam int CAT_L4OTH  = 7;
   localparam int CAT_IPV6   = 8;
   localparam int CAT_ICMP6  = 9;
   localparam int CAT_TCP6   = 10;
   localparam int CAT_UDP6   = 11;
   localparam int CAT_L4OTH6 = 12;
   localparam int CAT_L3OTH  = 13;
   localparam int CAT_DNS    = 14;
   localparam int CAT_SMTP   = 15;
   localparam int CAT_HTTP   = 16;
   localparam int CAT_POP3   = 17;
   localparam int CAT_IMAP   = 18;
   localparam int CAT_SMB    = 19;
   localparam int CAT_FTP    = 20;

   typedef logic [NUM_CATS-1:0] mask_type;

   // Header fields of one request held in the input stage
   typedef struct packed {
      logic        operation;
      logic [15:0] outer_ethertype;
      logic [15:0] tag1_ethertype;
      logic [15:0] tag2_ethertype;
      logic [7:0]  l4_protocol;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [INDEX_WIDTH-1:0] counter_index;
   } req_type;

   // Counter bank update control
   typedef struct packed {
      logic     en;
      mask_type mask;
   } upd_type;

endpackage

// ===== hw/rtl/packet_protocol_classifier.sv =====
// Top level of the packet protocol classifier: input stage, classifier, counters, result stage.
`timescale 1ns / 1ps

// Usage:
//   A request transfer (req_valid & req_ready) carries one packet's extracted
//   header fields. req_operation selects classify-and-count or counter read.
//   Classify: rsp_category_mask gives one bit per matched category and every
//   matched category counter advances by one, holding at its maximum;
//   rsp_counter_value is zero. Read: rsp_counter_value gives the counter
//   chosen by req_counter_index (zero above the last category) and
//   rsp_category_mask is zero.
//   A transferred request is held in the input register while classification
//   and the counter update run between it and the result register, which
//   drives rsp_valid. Throughput is one request per cycle while rsp_ready is
//   not stalled, set by the combinational classifier and counter increment;
//   a read always sees the counts of every earlier classify request.
//   Reset (synchronous, active high) clears all counters and empties both
//   stages. When the receiver stalls rsp_ready, the result register holds
//   and the input stage holds behind it; req_ready drops only once both
//   stages are full.

module packet_protocol_classifier (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_operation,
   input  logic [15:0]                     req_outer_ethertype,
   input  logic [15:0]                     req_tag1_ethertype,
   input  logic [15:0]                     req_tag2_ethertype,
   input  logic [7:0]                      req_l4_protocol,
   input  logic [15:0]                     req_source_port,
   input  logic [15:0]                     req_dest_port,
   input  logic [ppc_pkg::INDEX_WIDTH-1:0] req_counter_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ppc_pkg::NUM_CATS-1:0]    rsp_category_mask,
   output logic [ppc_pkg::VALUE_WIDTH-1:0] rsp_counter_value
);
   import ppc_pkg::*;

   req_type                s1_ff;
   logic                   s1_valid_ff;
   logic                   s1_advance;
   mask_type               class_mask;
   upd_type                upd;
   logic [VALUE_WIDTH-1:0] rd_value;

   logic                   rsp_valid_ff;
   mask_type               mask_ff;
   mask_type               mask_in;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;

   // Move the input stage on whenever the result register is free or draining.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;

   // Input stage: capture a transfer, drop the valid once passed on.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_ff.operation       <= req_operation;
         s1_ff.outer_ethertype <= req_outer_ethertype;
         s1_ff.tag1_ethertype  <= req_tag1_ethertype;
         s1_ff.tag2_ethertype  <= req_tag2_ethertype;
         s1_ff.l4_protocol     <= req_l4_protocol;
         s1_ff.source_port     <= req_source_port;
         s1_ff.dest_port       <= req_dest_port;
         s1_ff.counter_index   <= req_counter_index;
      end
   end

   ppc_classify u_classify (
      .outer_ethertype (s1_ff.outer_ethertype),
      .tag1_ethertype  (s1_ff.tag1_ethertype),
      .tag2_ethertype  (s1_ff.tag2_ethertype),
      .l4_protocol     (s1_ff.l4_protocol),
      .source_port     (s1_ff.source_port),
      .dest_port       (s1_ff.dest_port),
      .category_mask   (class_mask)
   );

   // Count only when a classify request leaves the input stage.
   assign upd.en   = s1_advance && (s1_ff.operation == OP_CLASSIFY);
   assign upd.mask = class_mask;

   ppc_counters u_counters (
      .clock    (clock),
      .reset    (reset),
      .upd      (upd),
      .rd_index (s1_ff.counter_index),
      .rd_value (rd_value)
   );

   always_comb begin
      case (s1_ff.operation)
         OP_READ: begin
            mask_in  = '0;
            value_in = rd_value;
         end
         default: begin
            mask_in  = class_mask;
            value_in = '0;
         end
      endcase
   end

   // Result register: load on advance, hold while stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         mask_ff  <= mask_in;
         value_ff <= value_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_category_mask = mask_ff;
   assign rsp_counter_value = value_ff;

endmodule

// ===== hw/rtl/ppc_classify.sv =====
// Header field classifier producing the category mask of one packet.
`timescale 1ns / 1ps

module ppc_classify (
   input  logic [15:0]       outer_ethertype,
   input  logic [15:0]       tag1_ethertype,
   input  logic [15:0]       tag2_ethertype,
   input  logic [7:0]        l4_protocol,
   input  logic [15:0]       source_port,
   input  logic [15:0]       dest_port,
   output ppc_pkg::mask_type category_mask
);
   import ppc_pkg::*;

   logic vlan;
   logic qinq;
   logic is_ipv4;
   logic is_ipv6;

   function automatic logic either_port(input logic [15:0] sp, input logic [15:0] dp,
                                        input logic [15:0] p);
      either_port = (sp == p) || (dp == p);
   endfunction

   assign vlan    = (outer_ethertype == ET_VLAN);
   assign qinq    = vlan && (tag1_ethertype == ET_VLAN);
   assign is_ipv4 = (outer_ethertype == ET_IPV4) || (vlan && tag1_ethertype == ET_IPV4) ||
                    (qinq && tag2_ethertype == ET_IPV4);
   assign is_ipv6 = (outer_ethertype == ET_IPV6) || (vlan && tag1_ethertype == ET_IPV6) ||
                    (qinq && tag2_ethertype == ET_IPV6);

   always_comb begin
      category_mask = '0;
      category_mask[CAT_VLAN] = vlan;
      category_mask[CAT_QINQ] = qinq;
      if (outer_ethertype == ET_ARP) begin
         category_mask[CAT_ARP] = 1'b1;
      end else if (is_ipv4) begin
         category_mask[CAT_IPV4] = 1'b1;
         if (l4_protocol == PR_UDP) begin
            category_mask[CAT_UDP] = 1'b1;
            category_mask[CAT_DNS] = either_port(source_port, dest_port, PORT_DNS);
         end else if (l4_protocol == PR_TCP) begin
            category_mask[CAT_TCP] = 1'b1;
            // first matching application wins
            if (dest_port == PORT_SMTP) begin
               category_mask[CAT_SMTP] = 1'b1;
            end else if (either_port(source_port, dest_port, PORT_HTTP) ||
                         either_port(source_port, dest_port, PORT_HTTP_ALT)) begin
               category_mask[CAT_HTTP] = 1'b1;
            end else if (dest_port == PORT_POP3) begin
               category_mask[CAT_POP3] = 1'b1;
            end else if (either_port(source_port, dest_port, PORT_IMAP)) begin
               category_mask[CAT_IMAP] = 1'b1;
            end else if (either_port(source_port, dest_port, PORT_NETBIOS) ||
                         either_port(source_port, dest_port, PORT_SMB)) begin
               category_mask[CAT_SMB] = 1'b1;
            end else if (either_port(source_port, dest_port, PORT_FTP_DATA) ||
                         either_port(source_port, dest_port, PORT_FTP_CTRL)) begin
               category_mask[CAT_FTP] = 1'b1;
            end
         end else if (l4_protocol == PR_ICMP4) begin
            category_mask[CAT_ICMP4] = 1'b1;
         end else begin
            category_mask[CAT_L4OTH] = 1'b1;
         end
      end else if (is_ipv6) begin
         category_mask[CAT_IPV6] = 1'b1;
         if (l4_protocol == PR_ICMP6) begin
            category_mask[CAT_ICMP6] = 1'b1;
         end else if (l4_protocol == PR_TCP) begin
            category_mask[CAT_TCP6] = 1'b1;
         end else if (l4_protocol == PR_UDP) begin
            category_mask[CAT_UDP6] = 1'b1;
         end else begin
            category_mask[CAT_L4OTH6] = 1'b1;
         end
      end else begin
         category_mask[CAT_L3OTH] = 1'b1;
      end
   end

endmodule

// ===== hw/rtl/ppc_counters.sv =====
// Bank of saturating category counters with one read port.
`timescale 1ns / 1ps

`include "packet_protocol_classifier_defines.svh"

module ppc_counters (
   input  logic                           clock,
   input  logic                           reset,
   input  ppc_pkg::upd_type               upd,
   input  logic [ppc_pkg::INDEX_WIDTH-1:0] rd_index,
   output logic [ppc_pkg::VALUE_WIDTH-1:0] rd_value
);
   import ppc_pkg::*;

   logic [NUM_CATS-1:0][COUNT_WIDTH-1:0] cnt_ff;
   logic [NUM_CATS-1:0][COUNT_WIDTH-1:0] cnt_in;

   // Advance each flagged counter unless it is already saturated.
   always_comb begin
      for (int i = 0; i < NUM_CATS; i++) begin
         if (upd.en && upd.mask[i] && !(&cnt_ff[i])) begin
            cnt_in[i] = cnt_ff[i] + COUNT_WIDTH'(1);
         end else begin
            cnt_in[i] = cnt_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Out-of-range index reads as zero.
   always_comb begin
      if (rd_index < INDEX_WIDTH'(NUM_CATS)) begin
         rd_value = VALUE_WIDTH'(cnt_ff[rd_index]);
      end else begin
         rd_value = '0;
      end
   end

   `PPC_ASSERT_NEXT(a_hold_when_idle, clock, reset, !upd.en, $stable(cnt_ff),
      "counters changed without an update")

   `PPC_ASSERT_IMP(a_read_out_of_range, clock, reset,
      rd_index >= INDEX_WIDTH'(NUM_CATS), rd_value == '0,
      "out-of-range counter read not zero")

   for (genvar g = 0; g < NUM_CATS; g++) begin : g_sat
      `PPC_ASSERT_NEXT(a_saturate, clock, reset, &cnt_ff[g], &cnt_ff[g],
         "saturated counter wrapped")
   end

endmodule
